>>> design/sfcd_pkg.sv
// Shared constants, codes and the CRC-8 step function of the short-frame deframer.
package sfcd_pkg;

  localparam int STORE_DEPTH = 64;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);

  localparam logic [7:0] HDR_MIN  = 8'h80;
  localparam logic [7:0] LEN_MASK = 8'h3F;
  localparam logic [7:0] CRC_POLY = 8'h4D;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  localparam logic IN_BYTE = 1'b0;
  localparam logic IN_TICK = 1'b1;

  localparam logic [1:0] OUT_DATA    = 2'd0;
  localparam logic [1:0] OUT_PAYLOAD = 2'd1;
  localparam logic [1:0] OUT_CRC_ERR = 2'd2;
  localparam logic [1:0] OUT_TIMEOUT = 2'd3;

  localparam logic REG_CRC_EN  = 1'b0;
  localparam logic REG_TIMEOUT = 1'b1;

  localparam logic MODE_IDLE  = 1'b0;
  localparam logic MODE_FRAME = 1'b1;

  // MSB-first CRC-8 of one byte, zero initial value
  function automatic logic [7:0] crc_byte(input logic [7:0] v);
    logic [7:0] c;
    c = v;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> design/sfcd_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module sfcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/short_frame_crc8_deframer.sv
// Short-frame deframer: header/length framing, optional CRC-8 check, idle timeout.
//
// Input stream s_*: one request is a received byte (s_tuser = 0, byte in s_tdata)
// or a time tick (s_tuser = 1). Output stream m_*: non-framed bytes, released
// frame payload bytes (m_tlast on the final one), CRC error and timeout drop
// reports, with the kind in m_tuser.
// Config port: cfg_we writes cfg_data into register cfg_index
// (0 = CRC check enable, 1 = idle timeout); write only while the block is idle.
//
// A tick or a byte is taken when the output register is free; its result (if
// any) appears on m_* in the next cycle. After a timeout drop report the byte's
// own result waits in a pending register until the output register is free.
// A released frame of N bytes is read back from the payload RAM byte by byte
// (read, then load of the output register, which waits while it is busy);
// no input is taken while a result is pending or a release runs.
// Reset (rst, synchronous) closes any open frame, clears the tick counter and
// CRC, sets CRC check off and timeout to 1000; the payload RAM is not cleared.
// While m_tvalid is high and m_tready is low the output register holds and
// s_tready drops until it can accept the next result.
module short_frame_crc8_deframer #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_tuser,   // [0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic [1:0]  m_tuser,   // [1:0] out_kind
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import sfcd_pkg::*;

  localparam int CMP_W = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

  localparam logic [1:0] ST_RUN       = 2'd0;
  localparam logic [1:0] ST_PEND      = 2'd1;
  localparam logic [1:0] ST_DRAIN_RD  = 2'd2;
  localparam logic [1:0] ST_DRAIN_OUT = 2'd3;

  logic [1:0]             state, state_next;
  logic                   crc_en;
  logic [15:0]            idle_timeout;
  logic                   mode, mode_next;
  logic [6:0]             bytes_held, bytes_held_next;
  logic [6:0]             expected_len, expected_len_next;
  logic [7:0]             running_crc, running_crc_next;
  logic [TIMER_WIDTH-1:0] idle_ticks, idle_ticks_next;
  logic [STORE_AW-1:0]    drain_idx, drain_idx_next;
  logic [6:0]             drain_cnt, drain_cnt_next;
  logic [1:0]             pend_kind, pend_kind_next;
  logic [7:0]             pend_byte, pend_byte_next;

  logic       out_free, load;
  logic [1:0] ld_kind;
  logic [7:0] ld_byte;
  logic       ld_last;
  logic       res_valid, timeout_hit, do_release, drain_last;
  logic [1:0] res_kind;
  logic [7:0] res_byte;
  logic       ram_we, ram_re;
  logic [7:0] ram_rdata;

  assign out_free   = !m_tvalid || m_tready;
  assign s_tready   = (state == ST_RUN) && out_free;
  assign drain_last = (({1'b0, drain_idx}) + 7'd1) == drain_cnt;

  sfcd_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(bytes_held[STORE_AW-1:0]),
    .wdata(s_tdata),
    .re   (ram_re),
    .raddr(drain_idx),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_next        = state;
    mode_next         = mode;
    bytes_held_next   = bytes_held;
    expected_len_next = expected_len;
    running_crc_next  = running_crc;
    idle_ticks_next   = idle_ticks;
    drain_idx_next    = drain_idx;
    drain_cnt_next    = drain_cnt;
    pend_kind_next    = pend_kind;
    pend_byte_next    = pend_byte;
    load        = 1'b0;
    ld_kind     = OUT_DATA;
    ld_byte     = 8'd0;
    ld_last     = 1'b0;
    res_valid   = 1'b0;
    res_kind    = OUT_DATA;
    res_byte    = 8'd0;
    timeout_hit = 1'b0;
    do_release  = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;

    case (state)
      ST_RUN: begin
        if (s_tvalid && s_tready) begin
          if (s_tuser[0] == IN_TICK) begin
            if (idle_ticks != '1) begin
              idle_ticks_next = idle_ticks + 1'b1;
            end
          end else begin
            idle_ticks_next = '0;
            if (CMP_W'(idle_ticks) > CMP_W'(idle_timeout)) begin
              timeout_hit       = (expected_len != 7'd0);
              mode_next         = MODE_IDLE;
              bytes_held_next   = 7'd0;
              expected_len_next = 7'd0;
            end
            if (mode_next == MODE_IDLE) begin
              if (s_tdata > HDR_MIN) begin
                mode_next         = MODE_FRAME;
                bytes_held_next   = 7'd0;
                expected_len_next = 7'(s_tdata & LEN_MASK) + 7'd1;
                if (crc_en) begin
                  running_crc_next = crc_byte(s_tdata);
                end
              end else begin
                res_valid = 1'b1;
                res_kind  = OUT_DATA;
                res_byte  = s_tdata;
              end
            end else if (bytes_held >= expected_len) begin
              if (crc_en && (s_tdata != running_crc)) begin
                res_valid         = 1'b1;
                res_kind          = OUT_CRC_ERR;
                mode_next         = MODE_IDLE;
                bytes_held_next   = 7'd0;
                expected_len_next = 7'd0;
              end else begin
                do_release = 1'b1;
              end
            end else begin
              ram_we          = 1'b1;
              bytes_held_next = bytes_held + 7'd1;
              if (crc_en) begin
                running_crc_next = crc_byte(running_crc ^ s_tdata);
              end else if (bytes_held_next == expected_len) begin
                do_release = 1'b1;
              end
            end
          end

          if (do_release) begin
            drain_cnt_next    = bytes_held_next;
            drain_idx_next    = '0;
            mode_next         = MODE_IDLE;
            bytes_held_next   = 7'd0;
            expected_len_next = 7'd0;
            state_next        = ST_DRAIN_RD;
          end

          if (timeout_hit) begin
            load    = 1'b1;
            ld_kind = OUT_TIMEOUT;
            if (res_valid) begin
              pend_kind_next = res_kind;
              pend_byte_next = res_byte;
              state_next     = ST_PEND;
            end
          end else if (res_valid) begin
            load    = 1'b1;
            ld_kind = res_kind;
            ld_byte = res_byte;
          end
        end
      end

      ST_PEND: begin
        if (out_free) begin
          load       = 1'b1;
          ld_kind    = pend_kind;
          ld_byte    = pend_byte;
          state_next = ST_RUN;
        end
      end

      ST_DRAIN_RD: begin
        ram_re     = 1'b1;
        state_next = ST_DRAIN_OUT;
      end

      ST_DRAIN_OUT: begin
        if (out_free) begin
          load    = 1'b1;
          ld_kind = OUT_PAYLOAD;
          ld_byte = ram_rdata;
          ld_last = drain_last;
          if (drain_last) begin
            state_next = ST_RUN;
          end else begin
            drain_idx_next = drain_idx + 1'b1;
            state_next     = ST_DRAIN_RD;
          end
        end
      end

      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_RUN;
      crc_en       <= 1'b0;
      idle_timeout <= TIMEOUT_RESET;
      mode         <= MODE_IDLE;
      bytes_held   <= 7'd0;
      expected_len <= 7'd0;
      running_crc  <= 8'd0;
      idle_ticks   <= '0;
      drain_idx    <= '0;
      drain_cnt    <= 7'd0;
      m_tvalid     <= 1'b0;
    end else begin
      state        <= state_next;
      mode         <= mode_next;
      bytes_held   <= bytes_held_next;
      expected_len <= expected_len_next;
      running_crc  <= running_crc_next;
      idle_ticks   <= idle_ticks_next;
      drain_idx    <= drain_idx_next;
      drain_cnt    <= drain_cnt_next;
      if (cfg_we) begin
        if (cfg_index == REG_CRC_EN) begin
          crc_en <= cfg_data[0];
        end else if (cfg_index == REG_TIMEOUT) begin
          idle_timeout <= cfg_data;
        end
      end
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_kind <= pend_kind_next;
    pend_byte <= pend_byte_next;
    if (load) begin
      m_tuser <= ld_kind;
      m_tdata <= ld_byte;
      m_tlast <= ld_last;
    end
  end

endmodule
